@@ rtl/pdd_pkg.sv @@
package pdd_pkg;

	// Field widths
	localparam int POS_W      = 24;
	localparam int ERR_W      = 25;
	localparam int PREV_W     = 26;
	localparam int GAIN_W     = 12;
	localparam int PROD_P_W   = ERR_W + GAIN_W + 1;
	localparam int ACC_W      = PREV_W + GAIN_W + 1;
	localparam int SPD_W      = ACC_W - 8;
	localparam int CMD_W      = 9;
	localparam int BYTE_W     = 8;
	localparam int SLEW_W     = CMD_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Stream widths
	localparam int IN_TDATA_W  = 4 * POS_W;
	localparam int OUT_FIELD_W = 2 * CMD_W + ERR_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// Reset values of the registers
	localparam logic [GAIN_W-1:0] GAIN_P_RST      = 12'd79;
	localparam logic [GAIN_W-1:0] GAIN_D_RST      = 12'd128;
	localparam logic [BYTE_W-1:0] SPEED_LIMIT_RST = 8'd150;
	localparam logic [BYTE_W-1:0] SLEW_STEP_RST   = 8'd5;
	localparam logic [BYTE_W-1:0] STILL_THR_RST   = 8'd2;
	localparam logic [BYTE_W-1:0] STILL_LIM_RST   = 8'd6;

	// Full jump allowed while the command magnitude is not rising in turn mode
	localparam logic [SLEW_W-1:0] SLEW_FULL_STEP = 11'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET      = 3'd0,
		REG_TURN_MODE   = 3'd1,
		REG_GAIN_P      = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_SPEED_LIMIT = 3'd4,
		REG_SLEW_STEP   = 3'd5,
		REG_STILL_THR   = 3'd6,
		REG_STILL_LIM   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]  target;
		logic              turn_mode;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_d;
		logic [BYTE_W-1:0] speed_limit;
		logic [BYTE_W-1:0] slew_step;
		logic [BYTE_W-1:0] still_threshold;
		logic [BYTE_W-1:0] still_limit;
	} cfg_t;

	// Slew limiter controls shared by both sides
	typedef struct packed {
		logic [BYTE_W-1:0] step;
		logic              ramp;
	} slew_ctl_t;

	typedef struct packed {
		logic             start_req;
		logic [POS_W-1:0] left_pos;
		logic [POS_W-1:0] right_pos;
		logic [POS_W-1:0] left_pos_aux;
		logic [POS_W-1:0] right_pos_aux;
	} in_item_t;

endpackage

@@ rtl/pd_drive_controller_with_slew.sv @@
// A transaction passes through the input register, the product register and the
// result register in that order before its result is valid.
// Throughput: one transaction per cycle unless m_axis_tready holds the output; the
// error, product and slew stages each close their own state loop, so back-to-back
// items never wait on each other. Reset (arst_n low, asynchronous): registers return
// to their defaults, PD and stall state clear to zero, and the pipeline empties.
module pd_drive_controller_with_slew
	import pdd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: left_pos[23:0], right_pos[47:24], left_pos_aux[71:48], right_pos_aux[95:72]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: start_req[0]
	input  logic                   s_axis_tuser,
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: left_cmd[8:0], right_cmd[17:9], pos_error[42:18], moving[43], zero[47:44]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cfg_t cfg_q;

	in_item_t s1_item;
	logic     s1_valid;

	logic                       s2_valid;
	logic signed [ACC_W-1:0]    s2_prod_p;
	logic signed [ACC_W-1:0]    s2_prod_d;
	logic        [ERR_W-1:0]    s2_err;
	logic                       s2_moving;

	logic                       s3_valid;
	logic        [CMD_W-1:0]    s3_left_cmd;
	logic        [CMD_W-1:0]    s3_right_cmd;
	logic        [ERR_W-1:0]    s3_err;
	logic                       s3_moving;

	logic signed [PREV_W-1:0]   prev_err_q;
	logic        [CMD_W-1:0]    left_speed_q;
	logic        [CMD_W-1:0]    right_speed_q;
	logic        [BYTE_W-1:0]   still_cnt_q;
	logic        [POS_W-1:0]    last_avg_q;
	logic        [POS_W-1:0]    last_target_q;

	logic adv3;
	logic adv2;
	logic load2_ok;
	logic adv1;

	// Configuration writes are always accepted and registered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target          <= '0;
			cfg_q.turn_mode       <= 1'b0;
			cfg_q.gain_p          <= GAIN_P_RST;
			cfg_q.gain_d          <= GAIN_D_RST;
			cfg_q.speed_limit     <= SPEED_LIMIT_RST;
			cfg_q.slew_step       <= SLEW_STEP_RST;
			cfg_q.still_threshold <= STILL_THR_RST;
			cfg_q.still_limit     <= STILL_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TARGET:      cfg_q.target          <= cfg_data[POS_W-1:0];
				REG_TURN_MODE:   cfg_q.turn_mode       <= cfg_data[0];
				REG_GAIN_P:      cfg_q.gain_p          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:      cfg_q.gain_d          <= cfg_data[GAIN_W-1:0];
				REG_SPEED_LIMIT: cfg_q.speed_limit     <= cfg_data[BYTE_W-1:0];
				REG_SLEW_STEP:   cfg_q.slew_step       <= cfg_data[BYTE_W-1:0];
				REG_STILL_THR:   cfg_q.still_threshold <= cfg_data[BYTE_W-1:0];
				REG_STILL_LIM:   cfg_q.still_limit     <= cfg_data[BYTE_W-1:0];
			endcase
		end
	end

	// Pipeline flow control: each stage advances when the next one is free or moving
	assign adv3          = !s3_valid || m_axis_tready;
	assign adv2          = s2_valid && adv3;
	assign load2_ok      = !s2_valid || adv3;
	assign adv1          = s1_valid && load2_ok;
	assign s_axis_tready = !s1_valid || load2_ok;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_item.start_req     <= s_axis_tuser;
			s1_item.left_pos      <= s_axis_tdata[POS_W-1:0];
			s1_item.right_pos     <= s_axis_tdata[2*POS_W-1:POS_W];
			s1_item.left_pos_aux  <= s_axis_tdata[3*POS_W-1:2*POS_W];
			s1_item.right_pos_aux <= s_axis_tdata[4*POS_W-1:3*POS_W];
		end
	end

	// Error path: measured value, error, derivative and both products
	logic signed [POS_W:0]      turn_diff;
	logic signed [POS_W:0]      turn_adj;
	logic        [POS_W-1:0]    measured;
	logic signed [ERR_W-1:0]    err_c;
	logic signed [PREV_W-1:0]   prev_c;
	logic signed [PREV_W-1:0]   deriv_c;
	logic signed [GAIN_W:0]     gp_s;
	logic signed [GAIN_W:0]     gd_s;
	logic signed [PROD_P_W-1:0] prod_p_c;
	logic signed [ACC_W-1:0]    prod_d_c;

	always_comb begin
		turn_diff = $signed({s1_item.right_pos[POS_W-1], s1_item.right_pos})
			- $signed({s1_item.left_pos[POS_W-1], s1_item.left_pos});
		// halve toward zero
		turn_adj  = turn_diff + $signed({{POS_W{1'b0}}, turn_diff[POS_W]});
		measured  = cfg_q.turn_mode ? turn_adj[POS_W:1] : s1_item.left_pos;
		err_c     = $signed({cfg_q.target[POS_W-1], cfg_q.target})
			- $signed({measured[POS_W-1], measured});
		prev_c    = s1_item.start_req ? '0 : prev_err_q;
		deriv_c   = $signed({err_c[ERR_W-1], err_c}) - prev_c;
		gp_s      = $signed({1'b0, cfg_q.gain_p});
		gd_s      = $signed({1'b0, cfg_q.gain_d});
		prod_p_c  = err_c * gp_s;
		prod_d_c  = deriv_c * gd_s;
	end

	// Stall detector on the auxiliary encoders
	logic [POS_W-1:0]  la_mag;
	logic [POS_W-1:0]  ra_mag;
	logic [POS_W:0]    avg_sum;
	logic [POS_W-1:0]  avg_c;
	logic [POS_W:0]    avg_diff;
	logic [POS_W:0]    avg_dmag;
	logic [BYTE_W-1:0] still_nxt;
	logic              moving_c;

	always_comb begin
		la_mag   = s1_item.left_pos_aux[POS_W-1]
			? POS_W'(~s1_item.left_pos_aux + 1'b1) : s1_item.left_pos_aux;
		ra_mag   = s1_item.right_pos_aux[POS_W-1]
			? POS_W'(~s1_item.right_pos_aux + 1'b1) : s1_item.right_pos_aux;
		avg_sum  = {1'b0, la_mag} + {1'b0, ra_mag};
		avg_c    = avg_sum[POS_W:1];
		avg_diff = {1'b0, last_avg_q} - {1'b0, avg_c};
		avg_dmag = avg_diff[POS_W] ? (POS_W+1)'(~avg_diff + 1'b1) : avg_diff;
		priority if (cfg_q.target != last_target_q) begin
			still_nxt = '0;
		end else if (avg_dmag < {{(POS_W+1-BYTE_W){1'b0}}, cfg_q.still_threshold}) begin
			still_nxt = (still_cnt_q == {BYTE_W{1'b1}}) ? still_cnt_q : still_cnt_q + 1'b1;
		end else begin
			still_nxt = '0;
		end
		moving_c = !(still_nxt > cfg_q.still_limit);
	end

	// Stage 2: product register, and the error and stall state advance with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid      <= 1'b0;
			prev_err_q    <= '0;
			still_cnt_q   <= '0;
			last_avg_q    <= '0;
			last_target_q <= '0;
		end else begin
			if (load2_ok) begin
				s2_valid <= s1_valid;
			end
			if (adv1) begin
				prev_err_q    <= $signed({err_c[ERR_W-1], err_c});
				still_cnt_q   <= still_nxt;
				last_avg_q    <= avg_c;
				last_target_q <= cfg_q.target;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			s2_prod_p <= ACC_W'(prod_p_c);
			s2_prod_d <= prod_d_c;
			s2_err    <= err_c;
			s2_moving <= moving_c;
		end
	end

	// Speed path: sum, scale toward zero, clamp
	logic signed [ACC_W-1:0] acc_c;
	logic signed [ACC_W-1:0] acc_adj;
	logic signed [SPD_W-1:0] spd_raw;
	logic signed [SPD_W-1:0] lim_pos;
	logic signed [SPD_W-1:0] lim_neg;
	logic signed [SPD_W-1:0] spd_clamp;
	logic        [CMD_W-1:0] spd_c;
	logic        [CMD_W-1:0] left_req;
	logic        [CMD_W-1:0] left_nxt;
	logic        [CMD_W-1:0] right_nxt;
	slew_ctl_t               slew_ctl;

	always_comb begin
		acc_c   = s2_prod_p + s2_prod_d;
		acc_adj = acc_c + $signed({{(ACC_W-BYTE_W){1'b0}}, {BYTE_W{acc_c[ACC_W-1]}}});
		spd_raw = acc_adj[ACC_W-1:8];
		lim_pos = $signed({{(SPD_W-BYTE_W){1'b0}}, cfg_q.speed_limit});
		lim_neg = -lim_pos;
		priority if (spd_raw > lim_pos) begin
			spd_clamp = lim_pos;
		end else if (spd_raw < lim_neg) begin
			spd_clamp = lim_neg;
		end else begin
			spd_clamp = spd_raw;
		end
		spd_c         = spd_clamp[CMD_W-1:0];
		left_req      = cfg_q.turn_mode ? CMD_W'(-spd_c) : spd_c;
		slew_ctl.step = cfg_q.slew_step;
		slew_ctl.ramp = !cfg_q.turn_mode;
	end

	pdd_slew u_slew_left (
		.ctl (slew_ctl),
		.cur (left_speed_q),
		.req (left_req),
		.nxt (left_nxt)
	);

	pdd_slew u_slew_right (
		.ctl (slew_ctl),
		.cur (right_speed_q),
		.req (spd_c),
		.nxt (right_nxt)
	);

	// Stage 3: result register, and the slew state advances with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid      <= 1'b0;
			left_speed_q  <= '0;
			right_speed_q <= '0;
		end else begin
			if (adv3) begin
				s3_valid <= s2_valid;
			end
			if (adv2) begin
				left_speed_q  <= left_nxt;
				right_speed_q <= right_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			s3_left_cmd  <= left_nxt;
			s3_right_cmd <= right_nxt;
			s3_err       <= s2_err;
			s3_moving    <= s2_moving;
		end
	end

	assign m_axis_tvalid = s3_valid;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, s3_moving, s3_err, s3_right_cmd, s3_left_cmd};

	// An empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s3_valid |-> s_axis_tready)
		else $error("input stalled with an empty result register");

	// Delivered commands match the slew state they came from
	a_cmd_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid |-> (s3_left_cmd == left_speed_q) && (s3_right_cmd == right_speed_q))
		else $error("result command differs from slew state");

	// Commands never wrap to the most negative code
	a_cmd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid |-> (s3_left_cmd != {1'b1, {(CMD_W-1){1'b0}}})
			&& (s3_right_cmd != {1'b1, {(CMD_W-1){1'b0}}}))
		else $error("command wrapped out of range");

	// A blocked product stage keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && !adv3) |=> s2_valid && $stable(s2_prod_p) && $stable(s2_err))
		else $error("product stage lost its item while blocked");

endmodule

@@ rtl/pdd_slew.sv @@
module pdd_slew
	import pdd_pkg::*;
(
	input  slew_ctl_t         ctl,
	input  logic [CMD_W-1:0]  cur,
	input  logic [CMD_W-1:0]  req,
	output logic [CMD_W-1:0]  nxt
);

	logic signed [SLEW_W-1:0] cur_w;
	logic signed [SLEW_W-1:0] req_w;
	logic signed [SLEW_W-1:0] step_w;
	logic signed [SLEW_W-1:0] lo_w;
	logic signed [SLEW_W-1:0] hi_w;
	logic signed [SLEW_W-1:0] res_w;
	logic        [SLEW_W-1:0] cur_mag;
	logic        [SLEW_W-1:0] req_mag;

	// Widen both commands and take their magnitudes
	always_comb begin
		cur_w   = SLEW_W'($signed(cur));
		req_w   = SLEW_W'($signed(req));
		cur_mag = cur_w[SLEW_W-1] ? SLEW_W'(-cur_w) : cur_w;
		req_mag = req_w[SLEW_W-1] ? SLEW_W'(-req_w) : req_w;
	end

	// Ramp by the step in ramp mode or while the magnitude rises, else allow a full jump
	always_comb begin
		if (ctl.ramp || (cur_mag < req_mag)) begin
			step_w = $signed({{(SLEW_W-BYTE_W){1'b0}}, ctl.step});
		end else begin
			step_w = $signed(SLEW_FULL_STEP);
		end
		lo_w = req_w - step_w;
		hi_w = req_w + step_w;
		priority if (cur_w < lo_w) begin
			res_w = cur_w + step_w;
		end else if (cur_w > hi_w) begin
			res_w = cur_w - step_w;
		end else begin
			res_w = req_w;
		end
		nxt = res_w[CMD_W-1:0];
	end

endmodule
